@@ rtl/core/gmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmf_pkg: shared definitions for the grid local maximum finder
// Sizes, sample and line-buffer word types, register indexes, result order.
// ----------------------------------------------------------------------------
package gmf_pkg;

    // Grid limits
    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;

    // Counter widths and widths that hold a size up to the limit
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RSIZE_W = $clog2(MAX_ROWS + 1);
    localparam int CSIZE_W = $clog2(MAX_COLS + 1);

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

    // Result order within one sample: bit positions in the hit vector
    localparam int RES_ABOVE = 0;
    localparam int RES_LEFT  = 1;
    localparam int RES_SELF  = 2;
    localparam int NUM_RES   = 3;

    typedef logic signed [DATA_W-1:0] t_sample;

    // One line-buffer column: the previous row and the row before it
    typedef struct packed {
        logic signed [DATA_W-1:0] newer;
        logic signed [DATA_W-1:0] older;
    } t_col_pair;

    // Everything the peak comparators look at for one sample
    typedef struct packed {
        t_col_pair                sample_col;
        t_col_pair                left_col;
        t_col_pair                right_col;
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] prev0;
        logic signed [DATA_W-1:0] prev1;
        logic                     has_r1;
        logic                     has_r2;
        logic                     has_c1;
        logic                     has_c2;
        logic                     last_row;
        logic                     last_col;
    } t_eval_in;

    // Which of the three candidate cells are peaks (MSB first: self, left, above)
    typedef struct packed {
        logic self_hit;
        logic left_hit;
        logic above_hit;
    } t_peak_hits;

    // Map a written row count onto 1..MAX_ROWS
    function automatic logic [RSIZE_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [RSIZE_W-1:0] res;
        if (v == '0) begin
            res = RSIZE_W'(1);
        end else if (32'(v) > 32'(MAX_ROWS)) begin
            res = RSIZE_W'(MAX_ROWS);
        end else begin
            res = RSIZE_W'(v);
        end
        return res;
    endfunction

    // Map a written column count onto 1..MAX_COLS
    function automatic logic [CSIZE_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [CSIZE_W-1:0] res;
        if (v == '0) begin
            res = CSIZE_W'(1);
        end else if (32'(v) > 32'(MAX_COLS)) begin
            res = CSIZE_W'(MAX_COLS);
        end else begin
            res = CSIZE_W'(v);
        end
        return res;
    endfunction

endpackage

@@ rtl/core/gmf_line_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmf_line_ram: two-row line buffer
// One word per column holding the previous row and the row before it.
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module gmf_line_ram (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [gmf_pkg::COL_W-1:0] i_waddr,
    input  gmf_pkg::t_col_pair       i_wdata,
    input  logic                     i_re,
    input  logic [gmf_pkg::COL_W-1:0] i_raddr,
    output gmf_pkg::t_col_pair       o_rdata
);

    gmf_pkg::t_col_pair r_mem [gmf_pkg::MAX_COLS];
    gmf_pkg::t_col_pair r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/gmf_peak_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmf_peak_eval: four-neighbour peak comparators
// Decides the cell above the new sample, the cell to its left (last row)
// and the new sample's own cell (final sample), ignoring off-grid neighbours.
// ----------------------------------------------------------------------------
module gmf_peak_eval (
    input  gmf_pkg::t_eval_in   i_eval,
    output gmf_pkg::t_peak_hits o_hits
);

    logic signed [gmf_pkg::DATA_W-1:0] above_ctr;
    logic signed [gmf_pkg::DATA_W-1:0] left_ctr;
    logic signed [gmf_pkg::DATA_W-1:0] self_ctr;

    assign above_ctr = $signed(i_eval.sample_col.newer);
    assign left_ctr  = $signed(i_eval.prev0);
    assign self_ctr  = $signed(i_eval.sample);

    // Cell one row up: needs the new sample below it and the right neighbour
    assign o_hits.above_hit = i_eval.has_r1
        && (!i_eval.has_r2   || above_ctr > $signed(i_eval.sample_col.older))
        && (!i_eval.has_c1   || above_ctr > $signed(i_eval.left_col.newer))
        && (i_eval.last_col  || above_ctr > $signed(i_eval.right_col.newer))
        && (above_ctr > self_ctr);

    // Cell to the left on the last row: the new sample is its right neighbour
    assign o_hits.left_hit = i_eval.last_row && i_eval.has_c1
        && (!i_eval.has_r1 || left_ctr > $signed(i_eval.left_col.newer))
        && (!i_eval.has_c2 || left_ctr > $signed(i_eval.prev1))
        && (left_ctr > self_ctr);

    // Final cell of the grid
    assign o_hits.self_hit = i_eval.last_row && i_eval.last_col
        && (!i_eval.has_r1 || self_ctr > $signed(i_eval.sample_col.newer))
        && (!i_eval.has_c1 || self_ctr > left_ctr);

endmodule

@@ rtl/core/grid_local_maximum_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_maximum_finder: four-neighbour strict local maximum detection
// Takes a grid of signed samples in raster order and reports each cell that
// is strictly greater than all of its in-grid four-connected neighbours.
// ----------------------------------------------------------------------------
// A sample is taken every clock cycle as long as it causes at most one peak
// and the output can take it; a sample that causes several peaks holds the
// input while its results leave one per cycle, as the output allows,
// via the single output register, after the input register. Earlier rows sit
// in one line-buffer RAM with one word per column, read once (one column
// ahead) and written once per sample. Peaks come out in decision order: the
// cell above the new sample, then on the last row the cell to its left, then
// on the final sample its own cell; o_last_of_run marks the last result of
// each sample. Writing grid_rows or grid_cols restarts the grid at row 0,
// column 0; a size of 0 is taken as 1 and a size above 1024 as 1024.
// ----------------------------------------------------------------------------
module grid_local_maximum_finder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [gmf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gmf_pkg::CFG_W-1:0]       i_cfg_data,
    // sample input
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [gmf_pkg::DATA_W-1:0] i_sample,
    // peak output
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [gmf_pkg::DATA_W-1:0] o_peak_value,
    output logic [gmf_pkg::POS_W-1:0]       o_peak_row,
    output logic [gmf_pkg::POS_W-1:0]       o_peak_col,
    output logic                            o_last_of_run
);

    // Grid size and raster position
    logic [gmf_pkg::RSIZE_W-1:0] r_rows, n_rows;
    logic [gmf_pkg::CSIZE_W-1:0] r_cols, n_cols;
    logic [gmf_pkg::ROW_W-1:0]   r_row, n_row;
    logic [gmf_pkg::COL_W-1:0]   r_col, n_col;

    // Input register
    logic                        r_s1_valid, n_s1_valid;
    logic [gmf_pkg::NUM_RES-1:0] r_s1_done, n_s1_done;
    gmf_pkg::t_sample            r_s1_sample;
    logic [gmf_pkg::ROW_W-1:0]   r_s1_row;
    logic [gmf_pkg::COL_W-1:0]   r_s1_col;
    logic                        r_s1_last_row;
    logic                        r_s1_last_col;
    logic                        r_s1_has_r1;
    logic                        r_s1_has_r2;
    logic                        r_s1_has_c1;
    logic                        r_s1_has_c2;
    logic                        r_s1_self;
    logic                        r_s1_fwd;
    gmf_pkg::t_col_pair          r_s1_fwd_data;

    // Column window and the two previous samples of the row
    gmf_pkg::t_col_pair          r_win0;
    gmf_pkg::t_col_pair          r_winm1;
    gmf_pkg::t_sample            r_prev0;
    gmf_pkg::t_sample            r_prev1;

    // Output register
    logic                        r_out_valid, n_out_valid;
    gmf_pkg::t_sample            r_out_value;
    logic [gmf_pkg::POS_W-1:0]   r_out_row;
    logic [gmf_pkg::POS_W-1:0]   r_out_col;
    logic                        r_out_last;

    logic                        in_xfer;
    logic                        last_row0;
    logic                        last_col0;
    logic [gmf_pkg::COL_W-1:0]   raddr;
    gmf_pkg::t_col_pair          ram_rdata;
    gmf_pkg::t_col_pair          rd_fix;
    gmf_pkg::t_col_pair          wdata;
    gmf_pkg::t_eval_in           eval_in;
    gmf_pkg::t_peak_hits         hits;
    logic [gmf_pkg::NUM_RES-1:0] pend;
    logic [gmf_pkg::NUM_RES-1:0] sel;
    logic [gmf_pkg::NUM_RES-1:0] rest;
    logic                        out_ready;
    logic                        emit;
    logic                        retire;
    gmf_pkg::t_sample            res_value;
    logic [gmf_pkg::POS_W-1:0]   res_row;
    logic [gmf_pkg::POS_W-1:0]   res_col;

    // Position flags for the sample at the input
    assign in_xfer   = i_valid && !o_stall;
    assign last_row0 = (gmf_pkg::RSIZE_W'(r_row) + gmf_pkg::RSIZE_W'(1)) >= r_rows;
    assign last_col0 = (gmf_pkg::CSIZE_W'(r_col) + gmf_pkg::CSIZE_W'(1)) >= r_cols;

    // Fetch the next column in raster order, wrapping to column 0
    assign raddr = last_col0 ? '0 : r_col + gmf_pkg::COL_W'(1);

    gmf_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_we    (retire),
        .i_waddr (r_s1_col),
        .i_wdata (wdata),
        .i_re    (in_xfer),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // Patch the fetched column with a write that raced the read
    assign rd_fix = r_s1_fwd ? r_s1_fwd_data : ram_rdata;

    // Shift the new sample into its column
    assign wdata.newer = r_s1_sample;
    assign wdata.older = r_win0.newer;

    // Gather comparator inputs
    always_comb begin
        eval_in.sample_col = r_win0;
        eval_in.left_col   = r_winm1;
        eval_in.right_col  = rd_fix;
        eval_in.sample     = r_s1_sample;
        eval_in.prev0      = r_prev0;
        eval_in.prev1      = r_prev1;
        eval_in.has_r1     = r_s1_has_r1;
        eval_in.has_r2     = r_s1_has_r2;
        eval_in.has_c1     = r_s1_has_c1;
        eval_in.has_c2     = r_s1_has_c2;
        eval_in.last_row   = r_s1_last_row;
        eval_in.last_col   = r_s1_last_col;
    end

    gmf_peak_eval u_peak_eval (
        .i_eval (eval_in),
        .o_hits (hits)
    );

    // Pick the next pending result in decision order
    assign pend      = hits & ~r_s1_done;
    assign sel       = pend & (~pend + gmf_pkg::NUM_RES'(1));
    assign rest      = pend & ~sel;
    assign out_ready = !r_out_valid || !i_stall;
    assign emit      = r_s1_valid && (pend != '0) && out_ready;
    assign retire    = r_s1_valid && ((pend == '0) || (emit && (rest == '0)));
    assign o_stall   = r_s1_valid && !retire;

    // Value and position of the selected result
    always_comb begin
        if (sel[gmf_pkg::RES_ABOVE]) begin
            res_value = r_win0.newer;
            res_row   = gmf_pkg::POS_W'(r_s1_row - gmf_pkg::ROW_W'(1));
            res_col   = gmf_pkg::POS_W'(r_s1_col);
        end else if (sel[gmf_pkg::RES_LEFT]) begin
            res_value = r_prev0;
            res_row   = gmf_pkg::POS_W'(r_s1_row);
            res_col   = gmf_pkg::POS_W'(r_s1_col - gmf_pkg::COL_W'(1));
        end else begin
            res_value = r_s1_sample;
            res_row   = gmf_pkg::POS_W'(r_s1_row);
            res_col   = gmf_pkg::POS_W'(r_s1_col);
        end
    end

    // Next state of size registers and raster position
    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        n_row  = r_row;
        n_col  = r_col;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                gmf_pkg::CFG_GRID_ROWS: n_rows = gmf_pkg::clamp_rows(i_cfg_data);
                gmf_pkg::CFG_GRID_COLS: n_cols = gmf_pkg::clamp_cols(i_cfg_data);
                default: ;
            endcase
            n_row = '0;
            n_col = '0;
        end else if (in_xfer) begin
            if (last_col0) begin
                n_col = '0;
                n_row = last_row0 ? '0 : r_row + gmf_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + gmf_pkg::COL_W'(1);
            end
        end
    end

    // Next state of pipeline control
    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1_done   = r_s1_done;
        n_out_valid = r_out_valid;
        if (in_xfer) begin
            n_s1_valid = 1'b1;
            n_s1_done  = '0;
        end else if (retire) begin
            n_s1_valid = 1'b0;
        end else if (emit) begin
            n_s1_done = r_s1_done | sel;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= gmf_pkg::RSIZE_W'(1);
            r_cols      <= gmf_pkg::CSIZE_W'(1);
            r_row       <= '0;
            r_col       <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_done   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rows      <= n_rows;
            r_cols      <= n_cols;
            r_row       <= n_row;
            r_col       <= n_col;
            r_s1_valid  <= n_s1_valid;
            r_s1_done   <= n_s1_done;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the transferred sample and its position flags
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_sample   <= i_sample;
            r_s1_row      <= r_row;
            r_s1_col      <= r_col;
            r_s1_last_row <= last_row0;
            r_s1_last_col <= last_col0;
            r_s1_has_r1   <= (r_row != '0);
            r_s1_has_r2   <= (r_row > gmf_pkg::ROW_W'(1));
            r_s1_has_c1   <= (r_col != '0);
            r_s1_has_c2   <= (r_col > gmf_pkg::COL_W'(1));
            r_s1_self     <= (raddr == r_col);
            r_s1_fwd      <= retire && (r_s1_col == raddr);
            r_s1_fwd_data <= wdata;
        end
    end

    // Advance the column window and the recent samples as a sample retires
    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_win0  <= r_s1_self ? wdata : rd_fix;
            r_winm1 <= r_win0;
            r_prev1 <= r_prev0;
            r_prev0 <= r_s1_sample;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value <= res_value;
            r_out_row   <= res_row;
            r_out_col   <= res_col;
            r_out_last  <= (rest == '0);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_peak_value  = r_out_value;
    assign o_peak_row    = r_out_row;
    assign o_peak_col    = r_out_col;
    assign o_last_of_run = r_out_last;

endmodule

@@ rtl/core/gmf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmf_checker: port-level checks for the grid local maximum finder
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module gmf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [gmf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input logic [gmf_pkg::CFG_W-1:0]         i_cfg_data,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic signed [gmf_pkg::DATA_W-1:0] i_sample,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [gmf_pkg::DATA_W-1:0] o_peak_value,
    input logic [gmf_pkg::POS_W-1:0]         o_peak_row,
    input logic [gmf_pkg::POS_W-1:0]         o_peak_col,
    input logic                              o_last_of_run
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_peak_value)
            && $stable(o_peak_row) && $stable(o_peak_col) && $stable(o_last_of_run))
        else $error("stalled result changed or dropped");

    // Drop any result on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A result that is not the last of its sample is followed at once by the next
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=> o_valid)
        else $error("gap inside the results of one sample");

    // A result appearing on an idle output comes from a sample transfer into the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result without a recent sample transfer");

endmodule

bind grid_local_maximum_finder gmf_checker u_gmf_checker (.*);
